// ----- src/suer_pkg.sv -----
// package for the event driven uart receiver
// holds event, status and register codes and the shared struct types; no dependencies
package suer_pkg;

  localparam int unsigned FrameLenW = 11;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned BitPosW   = 4;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [BitPosW-1:0] IdlePos = BitPosW'(10);
  localparam logic [BitPosW-1:0] StopPos = BitPosW'(9);

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_EDGE   = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_BYTE    = 3'd1,
    ST_LAST    = 3'd2,
    ST_FRAME   = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_LENGTH  = 1'd0,
    CFG_TIMEOUT_LIMIT = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [FrameLenW-1:0] frame_length;
    logic [TimeoutW-1:0]  timeout_limit;
  } cfg_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] data_byte;
  } res_t;

endpackage

// ----- src/suer_if.sv -----
// valid/ready channel interfaces for event words and result words
// depends on suer_pkg
interface suer_in_if;
  import suer_pkg::*;
  logic       valid;
  logic       ready;
  func_e      func;
  logic       line_level;

  modport source (output valid, output func, output line_level, input ready);
  modport sink (input valid, input func, input line_level, output ready);
endinterface

interface suer_out_if;
  import suer_pkg::*;
  logic       valid;
  logic       ready;
  status_e    status;
  logic [7:0] data_byte;

  modport source (output valid, output status, output data_byte, input ready);
  modport sink (input valid, input status, input data_byte, output ready);
endinterface

// ----- src/suer_rx.sv -----
// receiver state and per-event next-state and result logic
// depends on suer_pkg
module suer_rx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  suer_pkg::func_e      func_i,
  input  logic                 level_i,
  input  suer_pkg::cfg_t       cfg_i,
  output suer_pkg::res_t       res_o
);
  import suer_pkg::*;

  logic                 active_q, active_d;
  logic [BitPosW-1:0]   bit_pos_q, bit_pos_d;
  logic [7:0]           shift_q, shift_d;
  logic [FrameLenW-1:0] left_q, left_d;
  logic [TimeoutW-1:0]  tmo_q, tmo_d;
  logic [FrameLenW-1:0] left_dec;

  assign left_dec = left_q - FrameLenW'(1);

  always_comb begin
    active_d         = active_q;
    bit_pos_d        = bit_pos_q;
    shift_d          = shift_q;
    left_d           = left_q;
    tmo_d            = tmo_q;
    res_o.status     = ST_NONE;
    res_o.data_byte  = 8'h00;
    if (func_i == FUNC_START) begin
      active_d  = 1'b1;
      bit_pos_d = IdlePos;
      shift_d   = 8'h00;
      left_d    = (cfg_i.frame_length == '0) ? FrameLenW'(1) : cfg_i.frame_length;
      tmo_d     = '0;
    end else if (active_q) begin
      unique case (func_i)
        FUNC_SAMPLE: begin
          if (bit_pos_q >= IdlePos) begin
            // waiting for an edge
          end else if (bit_pos_q == '0) begin
            if (level_i) begin
              res_o.status = ST_FRAME;
              active_d     = 1'b0;
              bit_pos_d    = IdlePos;
            end else begin
              shift_d   = 8'h00;
              bit_pos_d = BitPosW'(1);
            end
          end else if (bit_pos_q < StopPos) begin
            shift_d   = {level_i, shift_q[7:1]};
            bit_pos_d = bit_pos_q + BitPosW'(1);
          end else if (!level_i) begin
            res_o.status = ST_FRAME;
            active_d     = 1'b0;
            bit_pos_d    = IdlePos;
          end else begin
            res_o.data_byte = shift_q;
            bit_pos_d       = IdlePos;
            left_d          = left_dec;
            if (left_dec == '0) begin
              res_o.status = ST_LAST;
              active_d     = 1'b0;
            end else begin
              res_o.status = ST_BYTE;
              tmo_d        = '0;
            end
          end
        end
        FUNC_EDGE: begin
          if (bit_pos_q >= IdlePos) begin
            bit_pos_d = '0;
          end
        end
        FUNC_TICK: begin
          if (tmo_q >= cfg_i.timeout_limit) begin
            res_o.status = ST_TIMEOUT;
            active_d     = 1'b0;
            bit_pos_d    = IdlePos;
          end else begin
            tmo_d = tmo_q + TimeoutW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      bit_pos_q <= IdlePos;
      shift_q   <= 8'h00;
      left_q    <= '0;
      tmo_q     <= '0;
    end else if (step_i) begin
      active_q  <= active_d;
      bit_pos_q <= bit_pos_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      tmo_q     <= tmo_d;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_pos_q <= IdlePos)
    else $error("bit position out of range");

  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> bit_pos_q == IdlePos)
    else $error("receiver not armed but inside a character");

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.status == ST_LAST |=> !active_q && bit_pos_q == IdlePos)
    else $error("final byte did not end reception");

  a_unarmed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !active_q && func_i != FUNC_START |-> res_o.status == ST_NONE)
    else $error("result reported while not armed");

endmodule

// ----- src/soft_uart_event_receiver.sv -----
// top level of the event driven 8n1 uart receiver
// depends on suer_pkg, suer_if and suer_rx
//
// in_i carries one event word per handshake: func (start, half-bit sample,
// falling edge, timebase tick) and the sampled line level. out_o returns
// exactly one result word per event: status and the received byte.
// an accepted event waits in the input register until the output register
// is free or being emptied, is processed by the receiver state logic and
// lands in the output register, where the result is offered until taken.
// one event per cycle is sustained while the sink takes every result; the
// state logic makes a single step of state update per event.
// when the sink stalls, the output register holds its word and the input
// register takes one more event; in_i.ready drops only when both are full.
// frame_length and timeout_limit are written through the cfg port, index 0
// and 1; the user must write them only while no event is in flight, which
// the block itself does not enforce. reset sets frame_length to 1,
// timeout_limit to 4999, leaves the receiver not armed and empties both registers.
module soft_uart_event_receiver (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [suer_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [suer_pkg::CfgDataW-1:0]   cfg_data_i,
  suer_in_if.sink                         in_i,
  suer_out_if.source                      out_o
);
  import suer_pkg::*;

  cfg_t  cfg_q;
  logic  in_vld_q;
  func_e in_func_q;
  logic  in_lvl_q;
  logic  out_vld_q;
  res_t  out_q;
  res_t  res;
  logic  adv;

  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length  <= FrameLenW'(1);
      cfg_q.timeout_limit <= TimeoutW'(4999);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_LENGTH:  cfg_q.frame_length  <= cfg_data_i[FrameLenW-1:0];
        CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_data_i[TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_func_q <= in_i.func;
      in_lvl_q  <= in_i.line_level;
    end
  end

  suer_rx u_rx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .func_i  (in_func_q),
    .level_i (in_lvl_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.status    = out_q.status;
  assign out_o.data_byte = out_q.data_byte;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free register");

  a_adv_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("processed word did not reach the output register");

  a_held_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |=> in_vld_q && $stable(in_func_q) && $stable(in_lvl_q))
    else $error("pending event word lost or changed");

endmodule

// ----- tb/tb_soft_uart_event_receiver.sv -----
`timescale 1ns / 100ps
// self-checking bench for soft_uart_event_receiver: random event words against a built-in
// predictor of the 8n1 receiver; depends on suer_pkg, suer_if and the receiver rtl
module tb_soft_uart_event_receiver;
  import suer_pkg::*;

  typedef struct packed {
    func_e func;
    logic  lvl;
  } ev_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  suer_in_if  ev_if ();
  suer_out_if res_if ();

  soft_uart_event_receiver uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (ev_if),
    .out_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver state and register copies
  logic [FrameLenW-1:0] sim_frame_len = FrameLenW'(1);
  logic [TimeoutW-1:0]  sim_timeout   = TimeoutW'(4999);
  logic                 sim_armed     = 1'b0;
  logic [BitPosW-1:0]   sim_pos       = IdlePos;
  logic [7:0]           sim_shift     = 8'h00;
  logic [FrameLenW-1:0] sim_left      = '0;
  logic [TimeoutW-1:0]  sim_ticks     = '0;

  ev_word_t ev_pending_q[$];
  res_t     rx_expected_q[$];

  int err_count    = 0;
  int gen_count    = 0;
  int ev_gap       = 0;
  int ev_sent      = 0;
  int ev_mode_left = 50;
  bit ev_calm      = 1'b0;
  bit ev_drain     = 1'b0;
  int res_wait     = 0;
  int res_mode_left = 80;
  bit res_calm     = 1'b0;
  ev_word_t ev_next;
  res_t     res_want;

  function automatic res_t rx_predict(func_e fn, logic lvl);
    res_t r;
    r.status    = ST_NONE;
    r.data_byte = 8'h00;
    if (fn == FUNC_START) begin
      sim_armed = 1'b1;
      sim_pos   = IdlePos;
      sim_shift = 8'h00;
      sim_left  = (sim_frame_len == '0) ? FrameLenW'(1) : sim_frame_len;
      sim_ticks = '0;
    end else if (sim_armed) begin
      case (fn)
        FUNC_SAMPLE: begin
          if (sim_pos < IdlePos) begin
            if (sim_pos == '0) begin
              if (lvl) begin
                r.status  = ST_FRAME;
                sim_armed = 1'b0;
                sim_pos   = IdlePos;
              end else begin
                sim_shift = 8'h00;
                sim_pos   = BitPosW'(1);
              end
            end else if (sim_pos < StopPos) begin
              sim_shift = {lvl, sim_shift[7:1]};
              sim_pos   = sim_pos + BitPosW'(1);
            end else if (!lvl) begin
              r.status  = ST_FRAME;
              sim_armed = 1'b0;
              sim_pos   = IdlePos;
            end else begin
              r.data_byte = sim_shift;
              sim_pos     = IdlePos;
              sim_left    = sim_left - FrameLenW'(1);
              if (sim_left == '0) begin
                r.status  = ST_LAST;
                sim_armed = 1'b0;
              end else begin
                r.status  = ST_BYTE;
                sim_ticks = '0;
              end
            end
          end
        end
        FUNC_EDGE: begin
          if (sim_pos >= IdlePos) sim_pos = '0;
        end
        default: begin
          if (sim_ticks >= sim_timeout) begin
            r.status  = ST_TIMEOUT;
            sim_armed = 1'b0;
            sim_pos   = IdlePos;
          end else begin
            sim_ticks = sim_ticks + TimeoutW'(1);
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void log_mismatch(string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void push_event(func_e fn, logic lvl);
    ev_pending_q.push_back('{func: fn, lvl: lvl});
    gen_count++;
  endfunction

  task automatic queue_byte(logic [7:0] b, logic start_lvl, logic stop_lvl);
    push_event(FUNC_EDGE, 1'b0);
    push_event(FUNC_SAMPLE, start_lvl);
    for (int i = 0; i < 8; i++) push_event(FUNC_SAMPLE, b[i]);
    push_event(FUNC_SAMPLE, stop_lvl);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_LENGTH) sim_frame_len = val[FrameLenW-1:0];
    else sim_timeout = val[TimeoutW-1:0];
  endtask

  task automatic wait_idle();
    while (ev_pending_q.size() != 0 || ev_if.valid || rx_expected_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // event driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_if.valid <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        rx_expected_q.push_back(rx_predict(ev_if.func, ev_if.line_level));
        ev_sent++;
        ev_gap = ev_calm ? 0 : pick_gap();
        if (--ev_mode_left == 0) begin
          ev_calm      = ($urandom_range(0, 3) == 0);
          ev_mode_left = $urandom_range(20, 120);
        end
        if (ev_sent % 173 == 0) ev_drain = 1'b1;
      end
      if (ev_drain && rx_expected_q.size() == 0) ev_drain = 1'b0;
      if (!ev_if.valid || ev_if.ready) begin
        if (ev_gap > 0) begin
          ev_gap--;
          ev_if.valid <= 1'b0;
        end else if (!ev_drain && ev_pending_q.size() != 0) begin
          ev_next = ev_pending_q.pop_front();
          ev_if.valid      <= 1'b1;
          ev_if.func       <= ev_next.func;
          ev_if.line_level <= ev_next.lvl;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (rx_expected_q.size() == 0) begin
          log_mismatch($sformatf("unexpected word: status %0d byte 0x%02h",
                                 res_if.status, res_if.data_byte));
        end else begin
          res_want = rx_expected_q.pop_front();
          if (res_if.status !== res_want.status || res_if.data_byte !== res_want.data_byte)
            log_mismatch($sformatf("status exp %0d got %0d, byte exp 0x%02h got 0x%02h",
                                   res_want.status, res_if.status,
                                   res_want.data_byte, res_if.data_byte));
        end
      end
      if (--res_mode_left <= 0) begin
        res_calm      = ($urandom_range(0, 3) == 0);
        res_mode_left = $urandom_range(30, 150);
      end
      if (res_wait > 0) begin
        res_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!res_calm && $urandom_range(0, 3) == 0) res_wait = pick_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int rand_items;
    int phase;
    int target;
    int n_bytes;
    int n_ticks;
    int mark;
    logic [CfgDataW-1:0] len_raw;
    logic [CfgDataW-1:0] tmo_raw;

    rand_items       = 0;
    phase            = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_FRAME_LENGTH;
    cfg_data_i       = '0;
    ev_if.valid      = 1'b0;
    ev_if.func       = FUNC_START;
    ev_if.line_level = 1'b0;
    res_if.ready     = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // not armed, then one good byte with an ignored sample and an ignored edge
    push_event(FUNC_SAMPLE, 1'b1);
    push_event(FUNC_EDGE, 1'b0);
    push_event(FUNC_TICK, 1'b1);
    push_event(FUNC_START, 1'b0);
    push_event(FUNC_SAMPLE, 1'b0);
    push_event(FUNC_EDGE, 1'b0);
    push_event(FUNC_SAMPLE, 1'b0);
    push_event(FUNC_EDGE, 1'b1);
    for (int i = 0; i < 8; i++) push_event(FUNC_SAMPLE, 1'(8'hA5 >> i));
    push_event(FUNC_SAMPLE, 1'b1);
    // bad start bit
    push_event(FUNC_START, 1'b1);
    push_event(FUNC_EDGE, 1'b0);
    push_event(FUNC_SAMPLE, 1'b1);
    wait_idle();

    // zero frame length and zero timeout, restart while armed, bad stop bit
    write_reg(CFG_FRAME_LENGTH, 16'h0000);
    write_reg(CFG_TIMEOUT_LIMIT, 16'h0000);
    @(negedge clk_i);
    push_event(FUNC_START, 1'b0);
    push_event(FUNC_TICK, 1'b0);
    push_event(FUNC_START, 1'b0);
    push_event(FUNC_START, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b0);
    wait_idle();

    while (rand_items < 1900) begin
      if (phase == 0) begin
        len_raw = 16'hFFFF;
        tmo_raw = 16'hFFFF;
      end else begin
        case ($urandom_range(0, 7))
          0: len_raw = 16'd0;
          1: len_raw = 16'd1;
          2: len_raw = {5'($urandom_range(0, 31)), 11'h7FF};
          3: len_raw = 16'd1024;
          4: len_raw = 16'($urandom());
          default: len_raw = 16'($urandom_range(2, 5));
        endcase
        case ($urandom_range(0, 5))
          0: tmo_raw = 16'd0;
          1: tmo_raw = 16'hFFFF;
          2: tmo_raw = 16'($urandom());
          default: tmo_raw = 16'($urandom_range(1, 12));
        endcase
      end
      write_reg(CFG_FRAME_LENGTH, len_raw);
      write_reg(CFG_TIMEOUT_LIMIT, tmo_raw);
      @(negedge clk_i);
      target = $urandom_range(100, 200);
      gen_count = 0;
      while (gen_count < target) begin
        if ($urandom_range(0, 99) < 80) begin
          mark = gen_count;
          push_event(FUNC_START, 1'($urandom_range(0, 1)));
          n_bytes = $urandom_range(1, 4);
          for (int b = 0; b < n_bytes; b++) begin
            n_ticks = (sim_timeout < 16) ? $urandom_range(0, sim_timeout + 1)
                                         : $urandom_range(0, 2);
            for (int t = 0; t < n_ticks; t++) push_event(FUNC_TICK, 1'($urandom_range(0, 1)));
            queue_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0),
                       ($urandom_range(0, 19) != 0));
            if ($urandom_range(0, 9) == 0)
              push_event(func_e'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
          end
          rand_items += gen_count - mark;
        end else begin
          // noise between frames
          repeat ($urandom_range(1, 3))
            push_event(func_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      end
      wait_idle();
      phase++;
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0 && rx_expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/suer_pkg.sv
src/suer_if.sv
src/suer_rx.sv
src/soft_uart_event_receiver.sv
tb/tb_soft_uart_event_receiver.sv
